FILE: design/rtsd_pkg.sv
// shared types and constants for the record table
`default_nettype none
package rtsd_pkg;

  localparam int CAPACITY   = 128;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP      = 16;
  localparam int GRP_W      = $clog2(GROUP);
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GSEL_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int PAD_W      = NUM_GROUPS * GROUP;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] record_id;
    logic [63:0]        payload;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [7:0] record_count;
  } res_t;

  typedef struct packed {
    logic live;
    logic capture;
    logic write;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_SELECT,
    S_APPLY
  } state_t;

endpackage
`default_nettype wire

FILE: design/record_table_insert_search_delete_top.sv
// record table top: command sequencer, count and chain of record cells
// an accepted transaction gives its result on done, registered from the update step
// one transaction at a time: compare, two locate stages, update, back to idle
// busy stays high from acceptance until the update; the receiver cannot stall
// the insert append and the delete shift both go through the cell chain at once
// reset clears the record count and control state; cell contents stay undefined
`default_nettype none
module record_table_insert_search_delete_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire rtsd_pkg::req_t request,
  output logic                busy,
  output logic                done,
  output rtsd_pkg::res_t      result
);
  import rtsd_pkg::*;

  state_t           state, state_next;
  req_t             req;
  logic [CNT_W-1:0] count, count_next;
  res_t             result_next;
  logic             capture, apply;

  logic [31:0]         ids      [CAPACITY];
  logic [63:0]         payloads [CAPACITY];
  logic [CAPACITY-1:0] hits;
  cell_ctl_t           ctls     [CAPACITY];

  logic             found;
  logic [IDX_W-1:0] index;
  logic             full;
  logic             do_write, do_shift;
  logic [CNT_W-1:0] index_ext;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_MATCH;
      S_MATCH:  state_next = S_GROUP;
      S_GROUP:  state_next = S_SELECT;
      S_SELECT: state_next = S_APPLY;
      S_APPLY:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy    = 1'b1;
    capture = 1'b0;
    apply   = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_MATCH: capture = 1'b1;
      S_APPLY: apply = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
    if (apply) begin
      result <= result_next;
    end
  end

  assign full      = (count == CNT_W'(CAPACITY));
  assign index_ext = CNT_W'(index);

  // command evaluation at the update step
  always_comb begin
    count_next  = count;
    do_write    = 1'b0;
    do_shift    = 1'b0;
    result_next = '{status: ST_OK, position: 7'd0, record_count: 8'(count)};
    if (apply) begin
      case (req.command)
        CMD_INSERT: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            do_write             = 1'b1;
            count_next           = count + CNT_W'(1);
            result_next.position = 7'(count);
          end
        end
        CMD_SEARCH: begin
          if (found) begin
            result_next.position = 7'(index);
          end else begin
            result_next.status = ST_MISSING;
          end
        end
        CMD_DELETE: begin
          if (found) begin
            do_shift             = 1'b1;
            count_next           = count - CNT_W'(1);
            result_next.position = 7'(index);
          end else begin
            result_next.status = ST_MISSING;
          end
        end
        default: ;
      endcase
      result_next.record_count = 8'(count_next);
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] nb_id;
    logic [63:0] nb_payload;

    if (i < CAPACITY - 1) begin : g_mid
      assign nb_id      = ids[i+1];
      assign nb_payload = payloads[i+1];
    end else begin : g_end
      assign nb_id      = ids[i];
      assign nb_payload = payloads[i];
    end

    always_comb begin
      ctls[i].live    = CNT_W'(i) < count;
      ctls[i].capture = capture;
      ctls[i].write   = do_write && (CNT_W'(i) == count);
      ctls[i].shift   = do_shift && (CNT_W'(i) >= index_ext)
                        && ((CNT_W'(i) + CNT_W'(1)) < count);
    end

    rtsd_cell u_cell (
      .clk         (clk),
      .ctl         (ctls[i]),
      .key         (req.record_id),
      .new_id      (req.record_id),
      .new_payload (req.payload),
      .nb_id       (nb_id),
      .nb_payload  (nb_payload),
      .id          (ids[i]),
      .payload     (payloads[i]),
      .hit         (hits[i])
    );
  end

  rtsd_locate u_locate (
    .clk   (clk),
    .hits  (hits),
    .found (found),
    .index (index)
  );

endmodule
`default_nettype wire

FILE: design/rtsd_cell.sv
// one table entry: stored record, new-record write, key compare and shift from the upper neighbor
`default_nettype none
module rtsd_cell (
  input  wire logic              clk,
  input  wire rtsd_pkg::cell_ctl_t ctl,
  input  wire logic [31:0]       key,
  input  wire logic [31:0]       new_id,
  input  wire logic [63:0]       new_payload,
  input  wire logic [31:0]       nb_id,
  input  wire logic [63:0]       nb_payload,
  output logic      [31:0]       id,
  output logic      [63:0]       payload,
  output logic                   hit
);
  import rtsd_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      id      <= new_id;
      payload <= new_payload;
    end else if (ctl.shift) begin
      id      <= nb_id;
      payload <= nb_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit <= ctl.live && (id == key);
    end
  end

endmodule
`default_nettype wire

FILE: design/rtsd_locate.sv
// two-stage first-match locator over the cell hit vector
`default_nettype none
module rtsd_locate (
  input  wire logic                          clk,
  input  wire logic [rtsd_pkg::CAPACITY-1:0] hits,
  output logic                               found,
  output logic      [rtsd_pkg::IDX_W-1:0]    index
);
  import rtsd_pkg::*;

  logic [PAD_W-1:0]      hits_pad;
  logic [NUM_GROUPS-1:0] grp_any_next;
  logic [GRP_W-1:0]      grp_first_next [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] grp_any;
  logic [GRP_W-1:0]      grp_first [NUM_GROUPS];
  logic                  found_next;
  logic [IDX_W-1:0]      index_next;

  assign hits_pad = PAD_W'(hits);

  // per group: any hit and lowest hit within the group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any_next[g]   = 1'b0;
      grp_first_next[g] = '0;
      for (int b = GROUP - 1; b >= 0; b--) begin
        if (hits_pad[g * GROUP + b]) begin
          grp_any_next[g]   = 1'b1;
          grp_first_next[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any   <= grp_any_next;
    grp_first <= grp_first_next;
  end

  // lowest group with a hit
  always_comb begin
    logic [GSEL_W+GRP_W-1:0] full_idx;
    full_idx   = '0;
    found_next = 1'b0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found_next = 1'b1;
        full_idx   = {GSEL_W'(g), grp_first[g]};
      end
    end
    index_next = full_idx[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    found <= found_next;
    index <= index_next;
  end

endmodule
`default_nettype wire
